@@ hdl/cmfp_pkg.sv @@
// Shared types and constants for the chat message field parser.
// Used by cmfp_step and chat_message_field_parser_core; no dependencies.
package cmfp_pkg;

  // Destination capacities of the string fields.
  localparam int ID_CAPACITY      = 64;
  localparam int NAME_CAPACITY    = 32;
  localparam int CONTENT_CAPACITY = 1024;

  // A character is kept while its index is below capacity minus one.
  localparam logic [16:0] ID_KEEP_LIMIT      = 17'(ID_CAPACITY - 1);
  localparam logic [16:0] NAME_KEEP_LIMIT    = 17'(NAME_CAPACITY - 1);
  localparam logic [16:0] CONTENT_KEEP_LIMIT = 17'(CONTENT_CAPACITY - 1);

  localparam logic [3:0]  MIN_PAYLOAD = 4'd13;
  localparam logic [15:0] TIME_BYTES  = 16'd8;

  // Flag bits that select the optional strings.
  localparam int FLAG_ORIG_BIT  = 2;
  localparam int FLAG_RECIP_BIT = 3;

  typedef enum logic [3:0] {
    PH_FLAGS    = 4'd0,
    PH_TIME     = 4'd1,
    PH_IDLEN    = 4'd2,
    PH_IDCHR    = 4'd3,
    PH_SNDLEN   = 4'd4,
    PH_SNDCHR   = 4'd5,
    PH_CLENHI   = 4'd6,
    PH_CLENLO   = 4'd7,
    PH_CONTENT  = 4'd8,
    PH_ORIGLEN  = 4'd9,
    PH_ORIGCHR  = 4'd10,
    PH_RECIPLEN = 4'd11,
    PH_RECIPCHR = 4'd12,
    PH_IGNORED  = 4'd13
  } phase_t;

  typedef enum logic [3:0] {
    TAG_FLAGS     = 4'd0,
    TAG_TIME      = 4'd1,
    TAG_ID_LEN    = 4'd2,
    TAG_ID_CHR    = 4'd3,
    TAG_SND_LEN   = 4'd4,
    TAG_SND_CHR   = 4'd5,
    TAG_CONT_LEN  = 4'd6,
    TAG_CONT_CHR  = 4'd7,
    TAG_ORIG_LEN  = 4'd8,
    TAG_ORIG_CHR  = 4'd9,
    TAG_RECIP_LEN = 4'd10,
    TAG_RECIP_CHR = 4'd11,
    TAG_IGNORED   = 4'd12
  } tag_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    phase_t      phase;
    logic [15:0] bytes_left;
    logic [15:0] str_index;
    logic [1:0]  option_bits;  // bit 0 orig present, bit 1 recip present
    logic [7:0]  len_high;
    logic [3:0]  total_seen;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:       PH_FLAGS,
    bytes_left:  16'd0,
    str_index:   16'd0,
    option_bits: 2'd0,
    len_high:    8'd0,
    total_seen:  4'd0
  };

  typedef struct packed {
    tag_t       tag;
    logic [7:0] byte_value;
    logic       keep_char;
    logic       is_final;
    status_t    status;
    logic       dropped;
  } parse_result_t;

endpackage

@@ hdl/chat_message_field_parser_core.sv @@
// Top level of the chat message field parser: input register, parser state,
// result register. Depends on cmfp_pkg and cmfp_step.
//
//   channel  direction  tdata                         tuser      tlast
//   in_      slave      data_byte                     -          end_of_payload
//   out_     master     byte, keep, status, dropped   field_tag  is_final
//
// Each beat passes through the input register and then the result register.
// One beat per cycle is sustained while out_tready is high; the per-byte
// state update is the only loop.
// A stall on out_tready fills the result register and then the input
// register before in_tready drops; nothing is lost or repeated.
// rst_n is synchronous and active low and returns the parser to the flags byte.
module chat_message_field_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_payload
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] byte_value, [8] keep_char,
                                  // [10:9] parse_status, [11] optional_dropped,
                                  // [15:12] zero
  output logic [3:0]  out_tuser,  // [3:0] field_tag
  output logic        out_tlast   // is_final
);
  import cmfp_pkg::*;

  logic          in_valid_r;
  logic [7:0]    in_byte_r;
  logic          in_last_r;
  parse_state_t  state_r;
  parse_state_t  state_nxt;
  parse_result_t step_res;
  parse_result_t out_res_r;
  logic          out_valid_r;
  logic          adv;

  cmfp_step u_step (
    .st             (state_r),
    .data_byte      (in_byte_r),
    .end_of_payload (in_last_r),
    .st_nxt         (state_nxt),
    .res            (step_res)
  );

  // The held byte moves on when the result register is empty or draining.
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.dropped, out_res_r.status,
                       out_res_r.keep_char, out_res_r.byte_value};
  assign out_tuser  = out_res_r.tag;
  assign out_tlast  = out_res_r.is_final;

  // After a final byte is processed the parser is back at the flags byte.
  a_restart_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_last_r |=> state_r.phase == PH_FLAGS && state_r.total_seen == 4'd0)
    else $error("parser state not cleared after final byte");

  // Status and drop flag only appear on a final result.
  a_status_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[11:9] == 3'd0)
    else $error("status reported on a non-final result");

  // Keep is set only on string characters.
  a_keep_on_chars: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |->
      (out_tuser == TAG_ID_CHR || out_tuser == TAG_SND_CHR ||
       out_tuser == TAG_CONT_CHR || out_tuser == TAG_ORIG_CHR ||
       out_tuser == TAG_RECIP_CHR))
    else $error("keep set on a non-character byte");

  // A drop is never reported together with a failing status.
  a_drop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> out_tdata[10:9] == ST_OK)
    else $error("drop flag with non-ok status");

endmodule

@@ hdl/cmfp_step.sv @@
// Per-byte field decode: next parser state and the result for one byte.
// Purely combinational; depends on cmfp_pkg.
module cmfp_step (
  input  cmfp_pkg::parse_state_t  st,
  input  logic [7:0]              data_byte,
  input  logic                    end_of_payload,
  output cmfp_pkg::parse_state_t  st_nxt,
  output cmfp_pkg::parse_result_t res
);
  import cmfp_pkg::*;

  phase_t      after_content;
  phase_t      after_orig;
  phase_t      chr_next;
  logic [16:0] keep_limit;
  logic [15:0] left_dec;
  logic [15:0] new_len;
  logic        char_phase;
  logic        len_phase;
  phase_t      len_chr;
  phase_t      len_skip;
  tag_t        tag_dec;
  parse_state_t upd;

  always_comb begin
    after_content = st.option_bits[0] ? PH_ORIGLEN :
                    (st.option_bits[1] ? PH_RECIPLEN : PH_IGNORED);
    after_orig    = st.option_bits[1] ? PH_RECIPLEN : PH_IGNORED;
    left_dec      = st.bytes_left - 16'd1;
    new_len       = (st.phase == PH_CLENLO) ? {st.len_high, data_byte}
                                            : {8'd0, data_byte};
  end

  // Decode of the current phase into the roles it plays.
  always_comb begin
    char_phase = 1'b0;
    len_phase  = 1'b0;
    keep_limit = NAME_KEEP_LIMIT;
    chr_next   = PH_IGNORED;
    len_chr    = PH_IGNORED;
    len_skip   = PH_IGNORED;
    tag_dec    = TAG_IGNORED;
    case (st.phase)
      PH_FLAGS:    tag_dec = TAG_FLAGS;
      PH_TIME:     tag_dec = TAG_TIME;
      PH_IDLEN: begin
        tag_dec = TAG_ID_LEN;  len_phase = 1'b1;
        len_chr = PH_IDCHR;    len_skip  = PH_SNDLEN;
      end
      PH_IDCHR: begin
        tag_dec = TAG_ID_CHR;  char_phase = 1'b1;
        keep_limit = ID_KEEP_LIMIT; chr_next = PH_SNDLEN;
      end
      PH_SNDLEN: begin
        tag_dec = TAG_SND_LEN; len_phase = 1'b1;
        len_chr = PH_SNDCHR;   len_skip  = PH_CLENHI;
      end
      PH_SNDCHR: begin
        tag_dec = TAG_SND_CHR; char_phase = 1'b1;
        chr_next = PH_CLENHI;
      end
      PH_CLENHI:   tag_dec = TAG_CONT_LEN;
      PH_CLENLO: begin
        tag_dec = TAG_CONT_LEN; len_phase = 1'b1;
        len_chr = PH_CONTENT;   len_skip  = after_content;
      end
      PH_CONTENT: begin
        tag_dec = TAG_CONT_CHR; char_phase = 1'b1;
        keep_limit = CONTENT_KEEP_LIMIT; chr_next = after_content;
      end
      PH_ORIGLEN: begin
        tag_dec = TAG_ORIG_LEN; len_phase = 1'b1;
        len_chr = PH_ORIGCHR;   len_skip  = after_orig;
      end
      PH_ORIGCHR: begin
        tag_dec = TAG_ORIG_CHR; char_phase = 1'b1;
        chr_next = after_orig;
      end
      PH_RECIPLEN: begin
        tag_dec = TAG_RECIP_LEN; len_phase = 1'b1;
        len_chr = PH_RECIPCHR;   len_skip  = PH_IGNORED;
      end
      PH_RECIPCHR: begin
        tag_dec = TAG_RECIP_CHR; char_phase = 1'b1;
        chr_next = PH_IGNORED;
      end
      default:     tag_dec = TAG_IGNORED;
    endcase
  end

  always_comb begin
    upd = st;
    if (st.total_seen < MIN_PAYLOAD) begin
      upd.total_seen = st.total_seen + 4'd1;
    end
    res.tag       = tag_dec;
    res.keep_char = 1'b0;
    if (st.phase == PH_FLAGS) begin
      upd.option_bits = {data_byte[FLAG_RECIP_BIT], data_byte[FLAG_ORIG_BIT]};
      upd.bytes_left  = TIME_BYTES;
      upd.phase       = PH_TIME;
    end else if (st.phase == PH_TIME) begin
      upd.bytes_left = left_dec;
      if (left_dec == 16'd0) begin
        upd.phase = PH_IDLEN;
      end
    end else if (st.phase == PH_CLENHI) begin
      upd.len_high = data_byte;
      upd.phase    = PH_CLENLO;
    end else if (len_phase) begin
      upd.bytes_left = new_len;
      upd.str_index  = 16'd0;
      upd.phase      = (new_len != 16'd0) ? len_chr : len_skip;
    end else if (char_phase) begin
      res.keep_char  = ({1'b0, st.str_index} < keep_limit);
      upd.str_index  = st.str_index + 16'd1;
      upd.bytes_left = left_dec;
      if (left_dec == 16'd0) begin
        upd.phase = chr_next;
      end
    end else begin
      upd.phase = PH_IGNORED;
    end

    res.byte_value = data_byte;
    res.is_final   = end_of_payload;
    res.status     = ST_OK;
    res.dropped    = 1'b0;
    st_nxt         = upd;
    if (end_of_payload) begin
      if (upd.total_seen < MIN_PAYLOAD) begin
        res.status = ST_SHORT;
      end else if (upd.phase < PH_ORIGLEN) begin
        res.status = ST_TRUNCATED;
      end else if (upd.phase == PH_ORIGCHR || upd.phase == PH_RECIPCHR) begin
        res.dropped = 1'b1;
      end
      // A new message starts with the next byte.
      st_nxt = STATE_RESET;
    end
  end

endmodule
